>>> hdl/first_fit_heap_allocator_assert.svh
// assertion macros for the first fit heap allocator checker
// needs nothing else; used by ffha_checker.sv
`ifndef FIRST_FIT_HEAP_ALLOCATOR_ASSERT_SVH
`define FIRST_FIT_HEAP_ALLOCATOR_ASSERT_SVH

// same-cycle implication, off during reset
`define FFHA_ASSERT_NOW(lbl, ck, rn, ante, cons) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
        else $error("ffha check failed");

// next-cycle implication, off during reset
`define FFHA_ASSERT_NEXT(lbl, ck, rn, ante, cons) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
        else $error("ffha check failed");

`endif

>>> hdl/ffha_pkg.sv
// shared constants and types of the first fit heap allocator
// no dependencies; used by the interfaces, the top level and the checker
`timescale 1ns / 1ps
`default_nettype none

package ffha_pkg;

    localparam int HEAP_BYTES = 4096;
    localparam int UNITS      = HEAP_BYTES / 8;
    localparam int UNIT_W     = $clog2(UNITS);
    localparam int IDX_W      = UNIT_W + 1;

    localparam int REQ_W      = 16;
    localparam int OFFS_W     = 12;
    localparam int STATUS_W   = 2;
    localparam int NEED_W     = REQ_W - 2;
    localparam int H_W        = OFFS_W - 3;
    localparam int WIDE_W     = (IDX_W > H_W) ? IDX_W : H_W;

    localparam logic CMD_ALLOC = 1'b0;
    localparam logic CMD_FREE  = 1'b1;

    typedef enum logic [STATUS_W-1:0] {
        STATUS_OK       = 2'd0,
        STATUS_NOSPACE  = 2'd1,
        STATUS_NOTCHUNK = 2'd2,
        STATUS_DBLFREE  = 2'd3
    } status_t;

    typedef struct packed {
        logic [UNIT_W-1:0] size;
        logic              free;
    } hdr_t;

endpackage

`default_nettype wire

>>> hdl/ffha_if.sv
// request and response channels of the first fit heap allocator
// depends on ffha_pkg for field widths
`timescale 1ns / 1ps
`default_nettype none

interface ffha_req_if;
    logic                       valid;
    logic                       ready;
    logic                       command;
    logic [ffha_pkg::REQ_W-1:0]  request_size;
    logic [ffha_pkg::OFFS_W-1:0] payload_offset;

    modport source (output valid, command, request_size, payload_offset, input ready);
    modport sink   (input valid, command, request_size, payload_offset, output ready);
endinterface

interface ffha_rsp_if;
    logic                         valid;
    logic                         ready;
    logic [ffha_pkg::STATUS_W-1:0] status;
    logic [ffha_pkg::OFFS_W-1:0]   granted_offset;

    modport source (output valid, status, granted_offset, input ready);
    modport sink   (input valid, status, granted_offset, output ready);
endinterface

`default_nettype wire

>>> hdl/ffha_ram.sv
// generic single write port, single read port ram with registered read
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

module ffha_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

>>> hdl/first_fit_heap_allocator.sv
// walk: an item reads k chunk headers (1 to 512) along the list from slot 0 before its result
// is valid; a misaligned free or offset 0 skips the walk and goes straight to the result state
// throughput: one item at a time, req.ready is high only while the sequencer is idle,
// and a result still waiting on rsp.ready holds the sequencer until it drains
// reset: rst_n (async, low) sets the slot 0 header to one free chunk covering the heap;
// the header ram is never cleared, every other slot is written before it is read
`timescale 1ns / 1ps
`default_nettype none

module first_fit_heap_allocator (
    input wire logic   clk,
    input wire logic   rst_n,
    ffha_req_if.sink   req,
    ffha_rsp_if.source rsp
);

    localparam int UNIT_W    = ffha_pkg::UNIT_W;
    localparam int IDX_W     = ffha_pkg::IDX_W;
    localparam int NEED_W    = ffha_pkg::NEED_W;
    localparam int OFFS_W    = ffha_pkg::OFFS_W;
    localparam int H_W       = ffha_pkg::H_W;
    localparam int WIDE_W    = ffha_pkg::WIDE_W;
    localparam int GOFF_W    = IDX_W + 3 + OFFS_W;
    localparam int REQ_W_SUM = ffha_pkg::REQ_W + 1;

    localparam logic [IDX_W-1:0]  UNITS_IDX = IDX_W'(ffha_pkg::UNITS);
    localparam logic [IDX_W-1:0]  LAST_IDX  = IDX_W'(ffha_pkg::UNITS - 1);
    localparam logic [IDX_W-1:0]  ONE_IDX   = IDX_W'(1);
    localparam logic [UNIT_W-1:0] ONE_UNIT  = UNIT_W'(1);

    // sequencer states
    typedef enum logic [7:0] {
        S_IDLE      = 8'b0000_0001,
        S_WALK      = 8'b0000_0010,  // one header per cycle along the chunk list
        S_FREE_NEXT = 8'b0000_0100,  // header after the freed chunk is on rdata
        S_FREE_WR_H = 8'b0000_1000,  // write freed header, merged with a free next chunk
        S_FREE_WR_P = 8'b0001_0000,  // grow a free previous chunk over it
        S_ALLOC_WR1 = 8'b0010_0000,  // write granted header
        S_ALLOC_WR2 = 8'b0100_0000,  // write split remainder header
        S_RESP      = 8'b1000_0000   // hand result to output register
    } state_t;

    state_t                 state_reg,      state_next;
    logic                   cmd_reg,        cmd_next;
    logic [NEED_W-1:0]      need_reg,       need_next;
    logic [H_W-1:0]         h_reg,          h_next;
    logic [IDX_W-1:0]       cur_reg,        cur_next;
    logic [UNIT_W-1:0]      hit_reg,        hit_next;
    logic [UNIT_W-1:0]      hit_sz_reg,     hit_sz_next;
    logic [UNIT_W-1:0]      merged_reg,     merged_next;
    logic [UNIT_W-1:0]      prev_reg,       prev_next;
    logic [UNIT_W-1:0]      prev_sz_reg,    prev_sz_next;
    logic                   prev_free_reg,  prev_free_next;
    ffha_pkg::status_t      status_reg,     status_next;
    logic [OFFS_W-1:0]      goff_reg,       goff_next;
    logic                   out_valid_reg,  out_valid_next;
    ffha_pkg::status_t      out_status_reg, out_status_next;
    logic [OFFS_W-1:0]      out_offset_reg, out_offset_next;
    ffha_pkg::hdr_t         slot0_reg,      slot0_next;

    // header ram port signals
    logic                   ram_we;
    logic [UNIT_W-1:0]      ram_waddr;
    ffha_pkg::hdr_t         ram_wdata;
    logic [UNIT_W-1:0]      ram_raddr;
    ffha_pkg::hdr_t         ram_rdata;

    // walk datapath
    ffha_pkg::hdr_t         hd;
    logic [IDX_W-1:0]       step_idx;
    logic [IDX_W-1:0]       split_idx;
    logic [REQ_W_SUM-1:0]   req_sum;
    logic [GOFF_W-1:0]      goff_wide;
    logic                   fit;
    logic                   split;

    ffha_ram #(
        .WIDTH ($bits(ffha_pkg::hdr_t)),
        .DEPTH (ffha_pkg::UNITS)
    ) u_hdr_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // slot 0 lives in flops so that reset defines it; the ram copy is ignored
    assign hd = (cur_reg == '0) ? slot0_reg : ram_rdata;

    // next header on the list, and the remainder header after a split
    assign step_idx  = cur_reg + IDX_W'(hd.size) + ONE_IDX;
    assign split_idx = IDX_W'(hit_reg) + IDX_W'(need_reg[UNIT_W-1:0]) + ONE_IDX;

    assign fit   = hd.free && (NEED_W'(hd.size) >= need_reg) && (cur_reg < LAST_IDX);
    assign split = (NEED_W'(hit_sz_reg) > need_reg) && (split_idx < UNITS_IDX);

    // rounded request in 8-byte units
    assign req_sum = REQ_W_SUM'(req.request_size) + REQ_W_SUM'(7);

    // payload byte offset of the granted chunk, cut to the field width
    assign goff_wide = GOFF_W'({IDX_W'(hit_reg) + ONE_IDX, 3'b000});

    assign req.ready          = (state_reg == S_IDLE);
    assign rsp.valid          = out_valid_reg;
    assign rsp.status         = out_status_reg;
    assign rsp.granted_offset = out_offset_reg;

    always_comb
    begin
        state_next      = state_reg;
        cmd_next        = cmd_reg;
        need_next       = need_reg;
        h_next          = h_reg;
        cur_next        = cur_reg;
        hit_next        = hit_reg;
        hit_sz_next     = hit_sz_reg;
        merged_next     = merged_reg;
        prev_next       = prev_reg;
        prev_sz_next    = prev_sz_reg;
        prev_free_next  = prev_free_reg;
        status_next     = status_reg;
        goff_next       = goff_reg;
        out_valid_next  = out_valid_reg;
        out_status_next = out_status_reg;
        out_offset_next = out_offset_reg;

        ram_we    = 1'b0;
        ram_waddr = hit_reg;
        ram_wdata = '{size: merged_reg, free: 1'b1};
        ram_raddr = '0;

        if (out_valid_reg && rsp.ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                // header 0 read is always on the port here, so the walk starts at once
                if (req.valid)
                begin
                    cmd_next  = req.command;
                    need_next = req_sum[REQ_W_SUM-1:3];
                    h_next    = req.payload_offset[OFFS_W-1:3] - H_W'(1);
                    cur_next  = '0;
                    goff_next = '0;
                    if ((req.command == ffha_pkg::CMD_FREE) &&
                        ((req.payload_offset[2:0] != 3'b000) ||
                         (req.payload_offset[OFFS_W-1:3] == '0)))
                    begin
                        status_next = ffha_pkg::STATUS_NOTCHUNK;
                        state_next  = S_RESP;
                    end
                    else
                    begin
                        state_next = S_WALK;
                    end
                end
            end

            S_WALK:
            begin
                if (cmd_reg == ffha_pkg::CMD_ALLOC)
                begin
                    if (fit)
                    begin
                        hit_next    = cur_reg[UNIT_W-1:0];
                        hit_sz_next = hd.size;
                        state_next  = S_ALLOC_WR1;
                    end
                    else if (step_idx >= UNITS_IDX)
                    begin
                        status_next = ffha_pkg::STATUS_NOSPACE;
                        state_next  = S_RESP;
                    end
                    else
                    begin
                        cur_next  = step_idx;
                        ram_raddr = step_idx[UNIT_W-1:0];
                    end
                end
                else if (WIDE_W'(cur_reg) == WIDE_W'(h_reg))
                begin
                    hit_next    = cur_reg[UNIT_W-1:0];
                    hit_sz_next = hd.size;
                    if (hd.free)
                    begin
                        status_next = ffha_pkg::STATUS_DBLFREE;
                        state_next  = S_RESP;
                    end
                    else if (step_idx < UNITS_IDX)
                    begin
                        cur_next   = step_idx;
                        ram_raddr  = step_idx[UNIT_W-1:0];
                        state_next = S_FREE_NEXT;
                    end
                    else
                    begin
                        // last chunk of the heap, nothing after it to merge
                        merged_next = hd.size;
                        state_next  = S_FREE_WR_H;
                    end
                end
                else
                begin
                    // remember this header as the one in front of the target
                    prev_next      = cur_reg[UNIT_W-1:0];
                    prev_sz_next   = hd.size;
                    prev_free_next = hd.free;
                    if (step_idx >= UNITS_IDX)
                    begin
                        status_next = ffha_pkg::STATUS_NOTCHUNK;
                        state_next  = S_RESP;
                    end
                    else
                    begin
                        cur_next  = step_idx;
                        ram_raddr = step_idx[UNIT_W-1:0];
                    end
                end
            end

            S_FREE_NEXT:
            begin
                if (hd.free)
                begin
                    merged_next = hit_sz_reg + hd.size + ONE_UNIT;
                end
                else
                begin
                    merged_next = hit_sz_reg;
                end
                state_next = S_FREE_WR_H;
            end

            S_FREE_WR_H:
            begin
                ram_we      = 1'b1;
                ram_waddr   = hit_reg;
                ram_wdata   = '{size: merged_reg, free: 1'b1};
                status_next = ffha_pkg::STATUS_OK;
                if ((hit_reg != '0) && prev_free_reg)
                begin
                    state_next = S_FREE_WR_P;
                end
                else
                begin
                    state_next = S_RESP;
                end
            end

            S_FREE_WR_P:
            begin
                ram_we     = 1'b1;
                ram_waddr  = prev_reg;
                ram_wdata  = '{size: prev_sz_reg + merged_reg + ONE_UNIT, free: 1'b1};
                state_next = S_RESP;
            end

            S_ALLOC_WR1:
            begin
                ram_we      = 1'b1;
                ram_waddr   = hit_reg;
                ram_wdata   = '{size: need_reg[UNIT_W-1:0], free: 1'b0};
                status_next = ffha_pkg::STATUS_OK;
                goff_next   = goff_wide[OFFS_W-1:0];
                if (split)
                begin
                    state_next = S_ALLOC_WR2;
                end
                else
                begin
                    state_next = S_RESP;
                end
            end

            S_ALLOC_WR2:
            begin
                ram_we     = 1'b1;
                ram_waddr  = split_idx[UNIT_W-1:0];
                ram_wdata  = '{size: hit_sz_reg - need_reg[UNIT_W-1:0] - ONE_UNIT,
                               free: 1'b1};
                state_next = S_RESP;
            end

            S_RESP:
            begin
                // wait for the output register to drain
                if (!out_valid_reg || rsp.ready)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = status_reg;
                    out_offset_next = goff_reg;
                    state_next      = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // writes to slot 0 also land in its flop copy
    always_comb
    begin
        slot0_next = slot0_reg;
        if (ram_we && (ram_waddr == '0))
        begin
            slot0_next = ram_wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            slot0_reg     <= '{size: UNIT_W'(ffha_pkg::UNITS - 1), free: 1'b1};
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            slot0_reg     <= slot0_next;
        end
    end

    // payload registers, no reset
    always_ff @(posedge clk)
    begin
        cmd_reg        <= cmd_next;
        need_reg       <= need_next;
        h_reg          <= h_next;
        cur_reg        <= cur_next;
        hit_reg        <= hit_next;
        hit_sz_reg     <= hit_sz_next;
        merged_reg     <= merged_next;
        prev_reg       <= prev_next;
        prev_sz_reg    <= prev_sz_next;
        prev_free_reg  <= prev_free_next;
        status_reg     <= status_next;
        goff_reg       <= goff_next;
        out_status_reg <= out_status_next;
        out_offset_reg <= out_offset_next;
    end

endmodule

`default_nettype wire

>>> hdl/ffha_checker.sv
// port level checks of the first fit heap allocator, bound to the top level
// depends on ffha_pkg and first_fit_heap_allocator_assert.svh
`timescale 1ns / 1ps
`default_nettype none

`include "first_fit_heap_allocator_assert.svh"

module ffha_checker (
    input wire logic                          clk,
    input wire logic                          rst_n,
    input wire logic                          req_valid,
    input wire logic                          req_ready,
    input wire logic                          rsp_valid,
    input wire logic                          rsp_ready,
    input wire logic [ffha_pkg::STATUS_W-1:0] rsp_status,
    input wire logic [ffha_pkg::OFFS_W-1:0]   rsp_granted_offset
);

    logic req_fire;
    logic rsp_ok;

    assign req_fire = req_valid && req_ready;
    assign rsp_ok   = rsp_valid && (rsp_status == ffha_pkg::STATUS_OK);

    // one item in flight: the sequencer leaves idle right after an accept
    `FFHA_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, req_fire, !req_ready)

    // failed results never carry an offset
    `FFHA_ASSERT_NOW(a_fail_zero_offset, clk, rst_n, rsp_valid && !rsp_ok,
        rsp_granted_offset == '0)

    // granted payloads start on a header boundary
    `FFHA_ASSERT_NOW(a_grant_aligned, clk, rst_n, rsp_ok,
        rsp_granted_offset[2:0] == 3'b000)

    // a stalled result holds
    `FFHA_ASSERT_NEXT(a_rsp_hold, clk, rst_n, rsp_valid && !rsp_ready,
        rsp_valid && $stable(rsp_status) && $stable(rsp_granted_offset))

endmodule

bind first_fit_heap_allocator ffha_checker u_ffha_checker (
    .clk                (clk),
    .rst_n              (rst_n),
    .req_valid          (req.valid),
    .req_ready          (req.ready),
    .rsp_valid          (rsp.valid),
    .rsp_ready          (rsp.ready),
    .rsp_status         (rsp.status),
    .rsp_granted_offset (rsp.granted_offset)
);

`default_nettype wire
